// ===== rtl/alab_pkg.sv =====
// Package with shared widths, constants and types of the ambient light brightness block.
package alab_pkg;

	// Field and state widths.
	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 12;
	localparam int BRIGHT_W      = 8;
	localparam int GAIN_W        = 12;
	localparam int ALPHA_W       = 16;
	localparam int TICK_W        = 16;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 3;

	// Derived datapath widths.
	localparam int SMOOTH_W  = SAMPLE_BITS + FRACTION_BITS;
	localparam int PROD_W    = SMOOTH_W + ALPHA_W;
	localparam int LEVEL_W   = SMOOTH_W + GAIN_W;
	localparam int DEN_W     = SAMPLE_BITS + FRACTION_BITS + BRIGHT_W;
	localparam int SCALED_W  = DEN_W + BRIGHT_W;
	localparam int QUO_IN_W  = SAMPLE_BITS + BRIGHT_W;

	// Constants of the brightness law.
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = {SAMPLE_BITS{1'b1}};
	localparam logic [DEN_W-1:0]       FULL_DEN    =
		{FULL_SCALE, {(FRACTION_BITS + BRIGHT_W){1'b0}}};
	localparam logic [PROD_W:0]        ROUND_HALF  = (PROD_W + 1)'(1) << (ALPHA_W - 1);
	localparam logic [GAIN_W-1:0]      GAIN_FLOOR  = GAIN_W'(26);
	localparam logic [SAMPLE_BITS-1:0] DARK_LIMIT  = SAMPLE_BITS'(5);
	localparam logic [BRIGHT_W-1:0]    DARK_BRIGHT = BRIGHT_W'(128);
	localparam logic [TICK_W-1:0]      TICK_MAX    = {TICK_W{1'b1}};

	// Configuration reset values.
	localparam logic                 RST_AUTO_ENABLE   = 1'b0;
	localparam logic [BRIGHT_W-1:0]  RST_MANUAL_BRIGHT = BRIGHT_W'(128);
	localparam logic [BRIGHT_W-1:0]  RST_BRIGHT_MIN    = BRIGHT_W'(10);
	localparam logic [BRIGHT_W-1:0]  RST_BRIGHT_MAX    = BRIGHT_W'(255);
	localparam logic [GAIN_W-1:0]    RST_SENSOR_GAIN   = GAIN_W'(256);
	localparam logic [ALPHA_W-1:0]   RST_SMOOTH_FACTOR = ALPHA_W'(6554);
	localparam logic [TICK_W-1:0]    RST_POLL_INTERVAL = TICK_W'(100);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AUTO_ENABLE       = 3'd0,
		CFG_MANUAL_BRIGHTNESS = 3'd1,
		CFG_BRIGHT_MIN        = 3'd2,
		CFG_BRIGHT_MAX        = 3'd3,
		CFG_SENSOR_GAIN       = 3'd4,
		CFG_SMOOTH_FACTOR     = 3'd5,
		CFG_POLL_INTERVAL     = 3'd6
	} cfg_idx_t;

	// Current register settings.
	typedef struct packed {
		logic                auto_enable;
		logic [BRIGHT_W-1:0] manual_brightness;
		logic [BRIGHT_W-1:0] bright_min;
		logic [BRIGHT_W-1:0] bright_max;
		logic [GAIN_W-1:0]   sensor_gain;
		logic [ALPHA_W-1:0]  smooth_factor;
		logic [TICK_W-1:0]   poll_interval;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic diff;
		logic mul;
		logic acc;
		logic gain;
		logic scale;
		logic div;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic upd;
	} dp_stat_t;

endpackage

// ===== rtl/alab_if.sv =====
// Stream interfaces for the input beats and the result beats.
interface alab_in_if
	import alab_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface alab_out_if
	import alab_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [BRIGHT_W-1:0]    brightness;
	logic [SAMPLE_BITS-1:0] smoothed_level;
	logic                   backlight_write;

	modport source (output valid, output brightness, output smoothed_level,
		output backlight_write, input ready);
	modport sink   (input valid, input brightness, input smoothed_level,
		input backlight_write, output ready);
endinterface

// ===== rtl/alab_cfg.sv =====
// Configuration register file of the ambient light brightness block.
module alab_cfg
	import alab_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_enable       <= RST_AUTO_ENABLE;
			cfg_q.manual_brightness <= RST_MANUAL_BRIGHT;
			cfg_q.bright_min        <= RST_BRIGHT_MIN;
			cfg_q.bright_max        <= RST_BRIGHT_MAX;
			cfg_q.sensor_gain       <= RST_SENSOR_GAIN;
			cfg_q.smooth_factor     <= RST_SMOOTH_FACTOR;
			cfg_q.poll_interval     <= RST_POLL_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AUTO_ENABLE:       cfg_q.auto_enable       <= cfg_data[0];
				CFG_MANUAL_BRIGHTNESS: cfg_q.manual_brightness <= cfg_data[BRIGHT_W-1:0];
				CFG_BRIGHT_MIN:        cfg_q.bright_min        <= cfg_data[BRIGHT_W-1:0];
				CFG_BRIGHT_MAX:        cfg_q.bright_max        <= cfg_data[BRIGHT_W-1:0];
				CFG_SENSOR_GAIN:       cfg_q.sensor_gain       <= cfg_data[GAIN_W-1:0];
				CFG_SMOOTH_FACTOR:     cfg_q.smooth_factor     <= cfg_data[ALPHA_W-1:0];
				CFG_POLL_INTERVAL:     cfg_q.poll_interval     <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/alab_ctrl.sv =====
// Controller state machine that sequences the brightness update.
module alab_ctrl
	import alab_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	output logic     result_valid,
	input  logic     result_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIFF  = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_ACC   = 8'b0000_1000,
		ST_GAIN  = 8'b0001_0000,
		ST_SCALE = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;
	logic   emit;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_ready && item_valid;
	assign slot_free    = !out_valid_q || result_ready;
	assign emit         = (state_q == ST_EMIT) && slot_free;
	assign result_valid = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = stat.upd ? ST_DIFF : ST_EMIT;
				end
			end
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_GAIN;
			ST_GAIN:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DIV;
			ST_DIV:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath commands.
	always_comb begin
		cmd.accept = accept;
		cmd.diff   = (state_q == ST_DIFF);
		cmd.mul    = (state_q == ST_MUL);
		cmd.acc    = (state_q == ST_ACC);
		cmd.gain   = (state_q == ST_GAIN);
		cmd.scale  = (state_q == ST_SCALE);
		cmd.div    = (state_q == ST_DIV);
		cmd.emit   = emit;
	end

	// An update beat enters the arithmetic chain.
	a_upd_enters_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stat.upd) |=> (state_q == ST_DIFF))
		else $error("update beat did not start the arithmetic chain");

	// A beat without update goes straight to the output stage.
	a_plain_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stat.upd) |=> (state_q == ST_EMIT))
		else $error("plain beat did not go to the output stage");

	// The division step is always followed by the output stage.
	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_EMIT))
		else $error("division step not followed by output stage");

endmodule

// ===== rtl/alab_dp.sv =====
// Datapath: smoother, tick counter, gain, scaling and mapping to brightness.
module alab_dp
	import alab_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic                   item_mode,
	input  logic [SAMPLE_BITS-1:0] item_sample,
	output logic [BRIGHT_W-1:0]    brightness,
	output logic [SAMPLE_BITS-1:0] smoothed_level,
	output logic                   backlight_write
);

	// Architectural state.
	logic [SMOOTH_W-1:0]    smoothed_q;
	logic                   ready_q;
	logic [TICK_W-1:0]      elapsed_q;
	logic [BRIGHT_W-1:0]    bright_q;

	// Working registers of the update chain.
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   wrote_q;
	logic [SMOOTH_W-1:0]    diff_q;
	logic                   neg_q;
	logic [PROD_W-1:0]      prod_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   sat_q;
	logic [QUO_IN_W-1:0]    scaled_q;

	// Output register.
	logic [BRIGHT_W-1:0]    out_bright_q;
	logic [SAMPLE_BITS-1:0] out_level_q;
	logic                   out_wrote_q;

	logic [TICK_W-1:0]      tick_next;
	logic                   upd;
	logic [SMOOTH_W-1:0]    target;
	logic [PROD_W:0]        round_sum;
	logic [SMOOTH_W-1:0]    step;
	logic [GAIN_W-1:0]      gain_eff;
	logic [BRIGHT_W-1:0]    hi;
	logic [BRIGHT_W-1:0]    lo;
	logic [BRIGHT_W-1:0]    span;
	logic [SCALED_W-1:0]    scaled_full;
	logic [BRIGHT_W-1:0]    quo_est;
	logic [SAMPLE_BITS:0]   quo_rem;
	logic [BRIGHT_W-1:0]    quo;

	// Tick counting saturates; an eligible tick starts an update.
	assign tick_next = (elapsed_q == TICK_MAX) ? TICK_MAX : elapsed_q + TICK_W'(1);
	assign upd       = item_mode && ready_q && cfg.auto_enable &&
		(tick_next >= cfg.poll_interval);
	assign stat.upd  = upd;

	// Smoother step, rounded half up in magnitude.
	assign target    = {sample_q, {FRACTION_BITS{1'b0}}};
	assign round_sum = {1'b0, prod_q} + ROUND_HALF;
	assign step      = round_sum[PROD_W-1:ALPHA_W];

	// Mapping range and gain floor.
	assign gain_eff = (cfg.sensor_gain < GAIN_FLOOR) ? GAIN_FLOOR : cfg.sensor_gain;
	assign hi       = cfg.bright_max;
	assign lo       = (cfg.bright_min > cfg.bright_max) ? cfg.bright_max : cfg.bright_min;
	assign span     = hi - lo;

	// Scaled level times span, with the power-of-two part of the divisor shifted out.
	assign scaled_full = level_q[DEN_W-1:0] * SCALED_W'(span);

	// Division by full scale: estimate by shift, then one correction.
	assign quo_est = scaled_q[QUO_IN_W-1:SAMPLE_BITS];
	assign quo_rem = {1'b0, scaled_q[SAMPLE_BITS-1:0]} + (SAMPLE_BITS + 1)'(quo_est);
	assign quo     = (quo_rem >= {1'b0, FULL_SCALE}) ? quo_est + BRIGHT_W'(1) : quo_est;

	// State updated by beats and by the update chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			ready_q    <= 1'b0;
			elapsed_q  <= '0;
			bright_q   <= DARK_BRIGHT;
		end else begin
			if (cmd.accept) begin
				if (!item_mode) begin
					smoothed_q <= {item_sample, {FRACTION_BITS{1'b0}}};
					bright_q   <= (item_sample < DARK_LIMIT) ? DARK_BRIGHT :
						cfg.manual_brightness;
					ready_q    <= 1'b1;
				end else begin
					elapsed_q <= upd ? '0 : tick_next;
				end
			end
			if (cmd.acc) begin
				smoothed_q <= neg_q ? smoothed_q - step : smoothed_q + step;
			end
			if (cmd.div) begin
				bright_q <= sat_q ? hi : lo + quo;
			end
		end
	end

	// Working registers of the chain, one operation per step.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= item_sample;
			wrote_q  <= upd;
		end
		if (cmd.diff) begin
			neg_q  <= (target < smoothed_q);
			diff_q <= (target < smoothed_q) ? smoothed_q - target : target - smoothed_q;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(diff_q) * PROD_W'(cfg.smooth_factor);
		end
		if (cmd.gain) begin
			level_q <= LEVEL_W'(smoothed_q) * LEVEL_W'(gain_eff);
		end
		if (cmd.scale) begin
			sat_q    <= (level_q >= LEVEL_W'(FULL_DEN));
			scaled_q <= scaled_full[SCALED_W-1:FRACTION_BITS + BRIGHT_W];
		end
		if (cmd.emit) begin
			out_bright_q <= bright_q;
			out_level_q  <= smoothed_q[SMOOTH_W-1:FRACTION_BITS];
			out_wrote_q  <= wrote_q;
		end
	end

	assign brightness      = out_bright_q;
	assign smoothed_level  = out_level_q;
	assign backlight_write = out_wrote_q;

	// A rising step never overshoots the new sample.
	a_rise_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && !neg_q) |=> (smoothed_q <= {sample_q, {FRACTION_BITS{1'b0}}}))
		else $error("smoother overshot the sample on a rising step");

	// A falling step never undershoots the new sample.
	a_fall_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && neg_q) |=> (smoothed_q >= {sample_q, {FRACTION_BITS{1'b0}}}))
		else $error("smoother undershot the sample on a falling step");

	// Mapped brightness stays within the effective range.
	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |=> ((bright_q <= hi) && (bright_q >= lo)))
		else $error("mapped brightness outside the min to max range");

	// An update clears the tick counter.
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && upd) |=> (elapsed_q == '0))
		else $error("tick counter not cleared by an update");

endmodule

// ===== rtl/ambient_light_auto_brightness_core.sv =====
// Top level of the ambient light auto-brightness block.
// Each input beat is a seed (mode 0) or a millisecond tick (mode 1) with a 12-bit light
// reading, and each one yields exactly one result beat carrying the current brightness,
// the integer part of the smoothed light level and a flag that marks a new backlight value.
// One beat is in work at a time. A seed, or a tick that only counts time, goes from
// the idle state straight to the output stage; a tick that runs an update first has the
// controller walk the chain difference, smoothing multiply, accumulate, gain multiply,
// span multiply and divide-by-full-scale, one step per cycle. The output stage loads
// the result register once the result slot is free. The next beat is taken in the
// cycle after the result is loaded, while that result may still wait downstream.
// Configuration registers are written through cfg_we, cfg_idx and cfg_data and
// should only change while no beat is in work.
module ambient_light_auto_brightness_core
	import alab_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	alab_in_if.sink               item,
	alab_out_if.source            result
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration registers.
	alab_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Sequencer and handshakes.
	alab_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Arithmetic and state.
	alab_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.item_mode       (item.mode),
		.item_sample     (item.sample),
		.brightness      (result.brightness),
		.smoothed_level  (result.smoothed_level),
		.backlight_write (result.backlight_write)
	);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the ambient light auto-brightness core.
`timescale 1ns / 100ps

module testbench
	import alab_pkg::*;
();

	// Kinds of input beat.
	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_IDLE      = 17;
	localparam int PHASE_COUNT   = 20;
	localparam int PHASE_BEATS   = 100;

	// One result beat as the block should present it.
	typedef struct packed {
		logic [BRIGHT_W-1:0]    brightness;
		logic [SAMPLE_BITS-1:0] smoothed_level;
		logic                   backlight_write;
	} light_result_t;

	// Tracks the block's state and settings and checks every result beat in order.
	class brightness_scoreboard;
		cfg_t                  regs;
		logic [SMOOTH_W-1:0]   smooth_acc;
		bit                    seeded;
		logic [TICK_W-1:0]     ticks;
		logic [BRIGHT_W-1:0]   backlight;
		light_result_t         expected_q[$];
		int                    errors;
		int                    checked;
		int                    updates;

		function new();
			regs.auto_enable       = RST_AUTO_ENABLE;
			regs.manual_brightness = RST_MANUAL_BRIGHT;
			regs.bright_min        = RST_BRIGHT_MIN;
			regs.bright_max        = RST_BRIGHT_MAX;
			regs.sensor_gain       = RST_SENSOR_GAIN;
			regs.smooth_factor     = RST_SMOOTH_FACTOR;
			regs.poll_interval     = RST_POLL_INTERVAL;
			smooth_acc = '0;
			seeded     = 0;
			ticks      = '0;
			backlight  = DARK_BRIGHT;
			errors     = 0;
			checked    = 0;
			updates    = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_AUTO_ENABLE:       regs.auto_enable       = data[0];
				CFG_MANUAL_BRIGHTNESS: regs.manual_brightness = data[BRIGHT_W-1:0];
				CFG_BRIGHT_MIN:        regs.bright_min        = data[BRIGHT_W-1:0];
				CFG_BRIGHT_MAX:        regs.bright_max        = data[BRIGHT_W-1:0];
				CFG_SENSOR_GAIN:       regs.sensor_gain       = data[GAIN_W-1:0];
				CFG_SMOOTH_FACTOR:     regs.smooth_factor     = data[ALPHA_W-1:0];
				CFG_POLL_INTERVAL:     regs.poll_interval     = data[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Moves the average toward the new reading by alpha of the gap, rounded half up.
		function void blend(logic [SAMPLE_BITS-1:0] reading);
			logic [63:0] target;
			logic [63:0] gap;
			logic [63:0] step;
			target = 64'(reading) << FRACTION_BITS;
			if (target >= 64'(smooth_acc)) begin
				gap = target - 64'(smooth_acc);
				step = (gap * 64'(regs.smooth_factor) + 64'(ROUND_HALF)) >> ALPHA_W;
				smooth_acc = SMOOTH_W'(64'(smooth_acc) + step);
			end else begin
				gap = 64'(smooth_acc) - target;
				step = (gap * 64'(regs.smooth_factor) + 64'(ROUND_HALF)) >> ALPHA_W;
				smooth_acc = SMOOTH_W'(64'(smooth_acc) - step);
			end
		endfunction

		// Scales the average by the gain and maps it linearly into min..max.
		function logic [BRIGHT_W-1:0] map_brightness();
			logic [63:0] hi;
			logic [63:0] lo;
			logic [63:0] gain;
			logic [63:0] level;
			logic [63:0] den;
			hi = 64'(regs.bright_max);
			lo = (regs.bright_min > regs.bright_max) ? hi : 64'(regs.bright_min);
			gain = (regs.sensor_gain < GAIN_FLOOR) ? 64'(GAIN_FLOOR) : 64'(regs.sensor_gain);
			level = 64'(smooth_acc) * gain;
			den = 64'(FULL_SCALE) << (FRACTION_BITS + BRIGHT_W);
			if (level >= den)
				return hi[BRIGHT_W-1:0];
			return BRIGHT_W'(lo + (level * (hi - lo)) / den);
		endfunction

		// Works out the result of one accepted input beat.
		function void note_input(logic mode, logic [SAMPLE_BITS-1:0] reading);
			light_result_t res;
			res.backlight_write = 1'b0;
			if (mode == MODE_SEED) begin
				smooth_acc = SMOOTH_W'(reading) << FRACTION_BITS;
				backlight = (reading < DARK_LIMIT) ? DARK_BRIGHT : regs.manual_brightness;
				seeded = 1;
			end else begin
				if (ticks != TICK_MAX)
					ticks = ticks + 1'b1;
				if (seeded && regs.auto_enable && ticks >= regs.poll_interval) begin
					ticks = '0;
					blend(reading);
					backlight = map_brightness();
					res.backlight_write = 1'b1;
					updates++;
				end
			end
			res.brightness     = backlight;
			res.smoothed_level = smooth_acc[SMOOTH_W-1 -: SAMPLE_BITS];
			expected_q.push_back(res);
		endfunction

		// Compares one result beat with the oldest expectation.
		function void check_result(logic [BRIGHT_W-1:0] brightness,
				logic [SAMPLE_BITS-1:0] smoothed_level, logic backlight_write);
			light_result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with no expectation waiting");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (brightness !== want.brightness) begin
				$error("brightness: expected %0d, got %0d", want.brightness, brightness);
				errors++;
			end
			if (smoothed_level !== want.smoothed_level) begin
				$error("smoothed_level: expected %0d, got %0d",
					want.smoothed_level, smoothed_level);
				errors++;
			end
			if (backlight_write !== want.backlight_write) begin
				$error("backlight_write: expected %0d, got %0d",
					want.backlight_write, backlight_write);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	alab_in_if  in_bus();
	alab_out_if out_bus();

	ambient_light_auto_brightness_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (in_bus),
		.result   (out_bus)
	);

	brightness_scoreboard board;
	int  cycle_count = 0;
	int  beats_sent = 0;
	int  cfg_writes = 0;
	int  rx_hold = 0;
	bit  rx_calm = 0;
	bit  tx_calm = 0;

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Input beats feed the predictor, result beats are checked against it.
	always @(posedge clk) begin
		if (arst_n && in_bus.valid && in_bus.ready)
			board.note_input(in_bus.mode, in_bus.sample);
	end

	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready)
			board.check_result(out_bus.brightness, out_bus.smoothed_level,
				out_bus.backlight_write);
	end

	// Result side: random stalls per beat, calm stretches, and long hold-offs on request.
	initial begin
		int stall;
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_bus.ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_bus.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_bus.ready = 1'b1;
			do @(posedge clk); while (!out_bus.valid);
			@(negedge clk);
		end
	end

	// Register write through the configuration port; called at a falling edge.
	task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.write_reg(idx, data);
		cfg_writes++;
	endtask

	// Offers one input beat after an idle gap and returns at the falling edge after it is taken.
	task automatic send_beat(logic mode, logic [SAMPLE_BITS-1:0] reading, int gap);
		if (gap > 0) begin
			in_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_bus.mode   = mode;
		in_bus.sample = reading;
		in_bus.valid  = 1'b1;
		do @(posedge clk); while (!in_bus.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Waits until every expected result has arrived and the block has settled.
	task automatic drain();
		in_bus.valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int tx_gap();
		return tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Light readings lean toward full scale, black and the dark-seed edge.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FULL_SCALE;
			2: return SAMPLE_BITS'($urandom_range(0, 6));
			default: return SAMPLE_BITS'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_bright();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'(255);
			default: return CFG_DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_DATA_W'(GAIN_FLOOR - 1'b1);
			2: return CFG_DATA_W'(GAIN_FLOOR);
			3: return CFG_DATA_W'(4095);
			4: return CFG_DATA_W'($urandom_range(0, 512));
			default: return CFG_DATA_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_alpha();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_DATA_W'(65535);
			2: return CFG_DATA_W'(1);
			3: return CFG_DATA_W'(32768);
			default: return CFG_DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Short intervals keep updates frequent; long ones show up now and then.
	function automatic logic [CFG_DATA_W-1:0] pick_poll();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return CFG_DATA_W'(65535);
			2: return CFG_DATA_W'($urandom_range(1, 400));
			default: return CFG_DATA_W'($urandom_range(1, 8));
		endcase
	endfunction

	// One random setting, then ticks with the odd reseed, mostly opened by a seed.
	task automatic random_phase(bit long_hold);
		logic mode;
		int   i;
		write_cfg(CFG_AUTO_ENABLE, CFG_DATA_W'($urandom_range(0, 7) != 0));
		write_cfg(CFG_MANUAL_BRIGHTNESS, pick_bright());
		write_cfg(CFG_BRIGHT_MIN, pick_bright());
		write_cfg(CFG_BRIGHT_MAX, pick_bright());
		write_cfg(CFG_SENSOR_GAIN, pick_gain());
		write_cfg(CFG_SMOOTH_FACTOR, pick_alpha());
		write_cfg(CFG_POLL_INTERVAL, pick_poll());
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		if (long_hold || $urandom_range(0, 5) == 0)
			rx_hold = $urandom_range(300, 500);
		for (i = 0; i < PHASE_BEATS; i++) begin
			if (i == 0)
				mode = ($urandom_range(0, 4) != 0) ? MODE_SEED : MODE_TICK;
			else
				mode = ($urandom_range(0, 24) == 0) ? MODE_SEED : MODE_TICK;
			send_beat(mode, pick_sample(), tx_gap());
		end
		drain();
	endtask

	initial begin
		int p;
		int i;
		board    = new();
		cfg_we   = 1'b0;
		cfg_idx  = CFG_AUTO_ENABLE;
		cfg_data = '0;
		in_bus.valid  = 1'b0;
		in_bus.mode   = MODE_SEED;
		in_bus.sample = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Ticks ahead of any seed only count; dark and normal seeds pick the start level.
		write_cfg(CFG_MANUAL_BRIGHTNESS, CFG_DATA_W'(200));
		send_beat(MODE_TICK, FULL_SCALE, 0);
		send_beat(MODE_SEED, DARK_LIMIT - 1'b1, 0);
		send_beat(MODE_SEED, DARK_LIMIT, 0);
		send_beat(MODE_TICK, SAMPLE_BITS'(100), 1);
		send_beat(MODE_TICK, '0, 0);
		drain();

		// Poll interval zero, gain below its floor, full smoothing weight, repeated seed.
		write_cfg(CFG_AUTO_ENABLE, CFG_DATA_W'(1));
		write_cfg(CFG_POLL_INTERVAL, '0);
		write_cfg(CFG_SENSOR_GAIN, '0);
		write_cfg(CFG_SMOOTH_FACTOR, CFG_DATA_W'(65535));
		write_cfg(CFG_BRIGHT_MIN, '0);
		write_cfg(CFG_BRIGHT_MAX, CFG_DATA_W'(255));
		send_beat(MODE_TICK, FULL_SCALE, 0);
		send_beat(MODE_TICK, '0, 2);
		send_beat(MODE_TICK, FULL_SCALE, 0);
		send_beat(MODE_SEED, FULL_SCALE, 0);
		send_beat(MODE_TICK, FULL_SCALE, 0);
		drain();

		// Top gain saturates the level, min above max collapses the range, zero alpha
		// freezes the average.
		write_cfg(CFG_SENSOR_GAIN, CFG_DATA_W'(4095));
		write_cfg(CFG_BRIGHT_MIN, CFG_DATA_W'(200));
		write_cfg(CFG_BRIGHT_MAX, CFG_DATA_W'(50));
		write_cfg(CFG_SMOOTH_FACTOR, '0);
		write_cfg(CFG_POLL_INTERVAL, CFG_DATA_W'(3));
		send_beat(MODE_TICK, '0, 0);
		send_beat(MODE_TICK, FULL_SCALE, 0);
		send_beat(MODE_TICK, SAMPLE_BITS'(1), 3);
		send_beat(MODE_TICK, SAMPLE_BITS'(2048), 0);
		send_beat(MODE_SEED, SAMPLE_BITS'(2048), 0);
		for (i = 0; i < 3; i++)
			send_beat(MODE_TICK, SAMPLE_BITS'(1), 0);
		drain();

		// With auto off time keeps counting, so the first tick after switching on updates.
		write_cfg(CFG_AUTO_ENABLE, '0);
		write_cfg(CFG_POLL_INTERVAL, CFG_DATA_W'(2));
		write_cfg(CFG_SMOOTH_FACTOR, CFG_DATA_W'(32768));
		write_cfg(CFG_SENSOR_GAIN, CFG_DATA_W'(256));
		write_cfg(CFG_BRIGHT_MIN, CFG_DATA_W'(10));
		write_cfg(CFG_BRIGHT_MAX, CFG_DATA_W'(255));
		for (i = 0; i < 3; i++)
			send_beat(MODE_TICK, FULL_SCALE, 0);
		drain();
		write_cfg(CFG_AUTO_ENABLE, CFG_DATA_W'(1));
		send_beat(MODE_TICK, FULL_SCALE, 0);
		send_beat(MODE_TICK, SAMPLE_BITS'(1), 0);
		drain();

		// Random settings and traffic; the third phase forces a long result hold-off.
		for (p = 0; p < PHASE_COUNT; p++)
			random_phase(p == 2);

		$display("Run summary: %0d input beats, %0d results checked, %0d backlight updates.",
			beats_sent, board.checked, board.updates);
		$display("Run summary: %0d register writes over %0d random settings and directed corners.",
			cfg_writes, PHASE_COUNT);
		if (board.errors == 0 && board.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
